// ===== rtl/kdrc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kdrc_pkg
// Operation, key class and register codes and reset values for the key
// debounce, repeat and classify core.
// ----------------------------------------------------------------------------
package kdrc_pkg;

   typedef logic [2:0] op_type;
   typedef logic [2:0] class_type;
   typedef logic [1:0] reg_index_type;

   localparam op_type OP_TICK     = 3'd0;
   localparam op_type OP_PRESS    = 3'd1;
   localparam op_type OP_REPEAT   = 3'd2;
   localparam op_type OP_SHORT    = 3'd3;
   localparam op_type OP_LONG     = 3'd4;
   localparam op_type OP_LONG_R   = 3'd5;
   localparam op_type OP_RPT_L    = 3'd6;
   localparam op_type OP_CLASSIFY = 3'd7;

   localparam class_type CLASS_NONE      = 3'd0;
   localparam class_type CLASS_SHORT     = 3'd1;
   localparam class_type CLASS_HELD      = 3'd2;
   localparam class_type CLASS_VERY_LONG = 3'd3;
   localparam class_type CLASS_LONG      = 3'd4;

   localparam reg_index_type REG_REPEAT_KEYS   = 2'd0;
   localparam reg_index_type REG_START_DELAY   = 2'd1;
   localparam reg_index_type REG_INTERVAL      = 2'd2;
   localparam reg_index_type REG_VERY_LONG_LIM = 2'd3;

   localparam logic [7:0] RST_REPEAT_KEYS   = 8'd255;
   localparam logic [7:0] RST_START_DELAY   = 8'd50;
   localparam logic [7:0] RST_INTERVAL      = 8'd20;
   localparam logic [7:0] RST_VERY_LONG_LIM = 8'd200;

   localparam logic [7:0] HOLD_MAX = 8'hFF;

endpackage

// ===== rtl/key_debounce_repeat_classifier_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// key_debounce_repeat_classifier_core
// Debounces eight active-low keys, raises press and repeat flags, answers
// flag queries and keeps a key class code.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one operation beat: a tick with a raw pin sample, one of
//   the flag queries, or a classify step, each with a key mask.
//   rsp_* returns one beat per request: the reported keys, the key class
//   after the operation and the debounced key state.
//   csr_* is an APB-style port for repeat_keys, repeat_start_delay,
//   repeat_interval and very_long_limit at byte addresses 0, 4, 8 and 12;
//   write it only while no request is in flight.
// Throughput:
//   An accepted request lands in the input register; its result moves into
//   the result register once that register is free, and rsp_valid then
//   rises and the beat can leave. One request per cycle is taken without a
//   gap while the result side keeps taking beats; all work is a single pass
//   of bitwise logic and 8-bit counters on the state.
// Reset:
//   Clears both stages, the flags, timers, hold count and class, sets the
//   debounce counters to all ones and loads the register defaults.
// Stall:
//   A held result keeps its register; the input register still fills, and
//   req_ready drops only when both stages hold a beat.
// ----------------------------------------------------------------------------
module key_debounce_repeat_classifier_core
   import kdrc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_operation,
   input  logic [7:0]  req_pin_levels,
   input  logic [7:0]  req_key_select,
   // result channel
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_selected_keys,
   output logic [2:0]  rsp_key_class,
   output logic [7:0]  rsp_debounced_keys,
   // configuration
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   // configuration registers
   logic [7:0] repeat_keys_ff;
   logic [7:0] start_delay_ff;
   logic [7:0] interval_ff;
   logic [7:0] very_long_lim_ff;
   logic       csr_write;
   reg_index_type csr_index;

   // input stage
   logic       s1_valid_ff;
   op_type     s1_op_ff;
   logic [7:0] s1_pins_ff;
   logic [7:0] s1_mask_ff;
   logic       s1_advance;
   logic       s2_ready;

   // key state
   logic [7:0] count_low_ff,   count_low_in;
   logic [7:0] count_high_ff,  count_high_in;
   logic [7:0] stable_ff,      stable_in;
   logic [7:0] press_ff,       press_in;
   logic [7:0] repeat_ff,      repeat_in;
   logic [7:0] timer_ff,       timer_in;
   logic [7:0] hold_ff,        hold_in;
   class_type  class_ff,       class_in;
   logic [7:0] selected_in;

   // result stage
   logic       rsp_valid_ff;
   logic [7:0] rsp_selected_ff;
   class_type  rsp_class_ff;
   logic [7:0] rsp_stable_ff;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite;
   assign csr_index  = csr_paddr[3:2];

   always_comb begin
      case (csr_index)
         REG_REPEAT_KEYS:   csr_prdata = {24'd0, repeat_keys_ff};
         REG_START_DELAY:   csr_prdata = {24'd0, start_delay_ff};
         REG_INTERVAL:      csr_prdata = {24'd0, interval_ff};
         REG_VERY_LONG_LIM: csr_prdata = {24'd0, very_long_lim_ff};
         default:           csr_prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         repeat_keys_ff   <= RST_REPEAT_KEYS;
         start_delay_ff   <= RST_START_DELAY;
         interval_ff      <= RST_INTERVAL;
         very_long_lim_ff <= RST_VERY_LONG_LIM;
      end else if (csr_write) begin
         case (csr_index)
            REG_REPEAT_KEYS:   repeat_keys_ff   <= csr_pwdata[7:0];
            REG_START_DELAY:   start_delay_ff   <= csr_pwdata[7:0];
            REG_INTERVAL:      interval_ff      <= csr_pwdata[7:0];
            REG_VERY_LONG_LIM: very_long_lim_ff <= csr_pwdata[7:0];
            default: begin
            end
         endcase
      end
   end

   // handshake: result register frees when taken, input stage follows
   assign s2_ready   = ~rsp_valid_ff | rsp_ready;
   assign s1_advance = s1_valid_ff & s2_ready;
   assign req_ready  = ~s1_valid_ff | s2_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_ready) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         s1_op_ff   <= req_operation;
         s1_pins_ff <= req_pin_levels;
         s1_mask_ff <= req_key_select;
      end
   end

   // one operation on the key state
   always_comb begin
      logic [7:0] chg;
      logic [7:0] chg_done;
      logic [7:0] timer_load;
      logic [7:0] timer_dec;
      logic [7:0] mask2;
      logic [7:0] rpt_taken;
      logic [7:0] short_keys;

      count_low_in  = count_low_ff;
      count_high_in = count_high_ff;
      stable_in     = stable_ff;
      press_in      = press_ff;
      repeat_in     = repeat_ff;
      timer_in      = timer_ff;
      hold_in       = hold_ff;
      class_in      = class_ff;
      selected_in   = 8'd0;

      chg        = 8'd0;
      chg_done   = 8'd0;
      timer_load = 8'd0;
      timer_dec  = 8'd0;
      mask2      = 8'd0;
      rpt_taken  = 8'd0;
      short_keys = 8'd0;

      case (s1_op_ff)
         OP_TICK: begin
            // two-bit vertical counter per key; toggle after four ticks
            chg           = stable_ff ^ ~s1_pins_ff;
            count_low_in  = ~(count_low_ff & chg);
            count_high_in = count_low_in ^ (count_high_ff & chg);
            chg_done      = chg & count_low_in & count_high_in;
            stable_in     = stable_ff ^ chg_done;
            press_in      = press_ff | (stable_in & chg_done);

            timer_load = ((stable_in & repeat_keys_ff) == 8'd0) ? start_delay_ff
                                                                 : timer_ff;
            timer_dec  = timer_load - 8'd1;
            if (timer_dec == 8'd0) begin
               timer_in  = interval_ff;
               repeat_in = repeat_ff | (stable_in & repeat_keys_ff);
            end else begin
               timer_in = timer_dec;
            end

            if (stable_in != 8'd0 && hold_ff != HOLD_MAX) begin
               hold_in = hold_ff + 8'd1;
            end
         end
         OP_PRESS: begin
            selected_in = s1_mask_ff & press_ff;
            press_in    = press_ff ^ selected_in;
         end
         OP_REPEAT: begin
            selected_in = s1_mask_ff & repeat_ff;
            repeat_in   = repeat_ff ^ selected_in;
         end
         OP_SHORT: begin
            selected_in = s1_mask_ff & ~stable_ff & press_ff;
            press_in    = press_ff ^ selected_in;
         end
         OP_LONG: begin
            rpt_taken   = s1_mask_ff & repeat_ff;
            repeat_in   = repeat_ff ^ rpt_taken;
            selected_in = rpt_taken & press_ff;
            press_in    = press_ff ^ selected_in;
         end
         OP_LONG_R: begin
            mask2       = s1_mask_ff & press_ff;
            rpt_taken   = mask2 & repeat_ff;
            repeat_in   = repeat_ff ^ rpt_taken;
            selected_in = rpt_taken & press_ff;
            press_in    = press_ff ^ selected_in;
         end
         OP_RPT_L: begin
            mask2       = s1_mask_ff & ~press_ff;
            selected_in = mask2 & repeat_ff;
            repeat_in   = repeat_ff ^ selected_in;
         end
         default: begin
            // classify: short release wins, then long, then class aging
            short_keys = s1_mask_ff & ~stable_ff & press_ff;
            if (short_keys != 8'd0) begin
               selected_in = short_keys;
               press_in    = press_ff ^ short_keys;
               class_in    = CLASS_SHORT;
            end else begin
               rpt_taken   = s1_mask_ff & repeat_ff;
               repeat_in   = repeat_ff ^ rpt_taken;
               selected_in = rpt_taken & press_ff;
               press_in    = press_ff ^ selected_in;
               if (selected_in != 8'd0) begin
                  class_in = CLASS_HELD;
                  hold_in  = 8'd0;
               end else if (class_ff == CLASS_HELD && hold_ff > very_long_lim_ff) begin
                  class_in = CLASS_VERY_LONG;
               end else if (class_ff == CLASS_HELD && (stable_ff & s1_mask_ff) == 8'd0) begin
                  class_in = CLASS_LONG;
               end
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_low_ff  <= 8'hFF;
         count_high_ff <= 8'hFF;
         stable_ff     <= 8'd0;
         press_ff      <= 8'd0;
         repeat_ff     <= 8'd0;
         timer_ff      <= 8'd0;
         hold_ff       <= 8'd0;
         class_ff      <= CLASS_NONE;
      end else if (s1_advance) begin
         count_low_ff  <= count_low_in;
         count_high_ff <= count_high_in;
         stable_ff     <= stable_in;
         press_ff      <= press_in;
         repeat_ff     <= repeat_in;
         timer_ff      <= timer_in;
         hold_ff       <= hold_in;
         class_ff      <= class_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s2_ready) begin
         rsp_valid_ff <= s1_valid_ff;
      end
   end

   // hold the result while the receiver stalls
   always_ff @(posedge clock) begin
      if (s1_advance) begin
         rsp_selected_ff <= selected_in;
         rsp_class_ff    <= class_in;
         rsp_stable_ff   <= stable_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_selected_keys  = rsp_selected_ff;
   assign rsp_key_class      = rsp_class_ff;
   assign rsp_debounced_keys = rsp_stable_ff;

endmodule

// ===== verif/key_report_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// key_report_checker
// Watches the request, result and register ports of the key debounce core.
// It keeps its own copy of the debounce counters, flags, timers and key
// class, works out the report for every accepted request and compares each
// result beat with the oldest outstanding report.
// ----------------------------------------------------------------------------
module key_report_checker
   import kdrc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [2:0]  req_operation,
   input  logic [7:0]  req_pin_levels,
   input  logic [7:0]  req_key_select,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [7:0]  rsp_selected_keys,
   input  logic [2:0]  rsp_key_class,
   input  logic [7:0]  rsp_debounced_keys,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic        csr_pready,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output int          fail_count,
   output int          pending_count
);

   typedef struct packed {
      logic [7:0] reported;
      class_type  key_class;
      logic [7:0] debounced;
   } key_report_type;

   key_report_type report_q[$];

   // register copies
   logic [7:0] rpt_key_set;
   logic [7:0] start_delay;
   logic [7:0] repeat_period;
   logic [7:0] very_long_lim;

   // key state
   logic [7:0] vc_low;
   logic [7:0] vc_high;
   logic [7:0] keys_down;
   logic [7:0] press_pend;
   logic [7:0] repeat_pend;
   logic [7:0] repeat_timer;
   logic [7:0] hold_ticks;
   class_type  class_now;

   int mismatches = 0;
   int beat_no = 0;

   initial begin
      fail_count    = 0;
      pending_count = 0;
   end

   function automatic logic [7:0] take_press_flags(input logic [7:0] sel);
      logic [7:0] hit;
      hit        = sel & press_pend;
      press_pend = press_pend ^ hit;
      return hit;
   endfunction

   function automatic logic [7:0] take_repeat_flags(input logic [7:0] sel);
      logic [7:0] hit;
      hit         = sel & repeat_pend;
      repeat_pend = repeat_pend ^ hit;
      return hit;
   endfunction

   function automatic void debounce_tick(input logic [7:0] pins);
      logic [7:0] diff;
      diff      = keys_down ^ ~pins;
      vc_low    = ~(vc_low & diff);
      vc_high   = vc_low ^ (vc_high & diff);
      diff      = diff & vc_low & vc_high;
      keys_down = keys_down ^ diff;
      press_pend = press_pend | (keys_down & diff);

      // reload the start delay while no repeat key is down; the timer wraps
      if ((keys_down & rpt_key_set) == 8'h00)
         repeat_timer = start_delay;
      repeat_timer = repeat_timer - 8'd1;
      if (repeat_timer == 8'h00) begin
         repeat_timer = repeat_period;
         repeat_pend  = repeat_pend | (keys_down & rpt_key_set);
      end
      if (keys_down != 8'h00 && hold_ticks != HOLD_MAX)
         hold_ticks = hold_ticks + 8'd1;
   endfunction

   function automatic logic [7:0] classify_keys(input logic [7:0] sel);
      logic [7:0] hit;
      hit = take_press_flags(sel & ~keys_down);
      if (hit != 8'h00) begin
         class_now = CLASS_SHORT;
         return hit;
      end
      hit = take_press_flags(take_repeat_flags(sel));
      if (hit != 8'h00) begin
         class_now  = CLASS_HELD;
         hold_ticks = 8'h00;
         return hit;
      end
      if (class_now == CLASS_HELD && hold_ticks > very_long_lim)
         class_now = CLASS_VERY_LONG;
      else if (class_now == CLASS_HELD && (keys_down & sel) == 8'h00)
         class_now = CLASS_LONG;
      return 8'h00;
   endfunction

   function automatic key_report_type predict_report(input op_type op,
                                                     input logic [7:0] pins,
                                                     input logic [7:0] sel);
      key_report_type rep;
      logic [7:0]     hit;
      hit = 8'h00;
      case (op)
         OP_TICK:   debounce_tick(pins);
         OP_PRESS:  hit = take_press_flags(sel);
         OP_REPEAT: hit = take_repeat_flags(sel);
         OP_SHORT:  hit = take_press_flags(sel & ~keys_down);
         OP_LONG:   hit = take_press_flags(take_repeat_flags(sel));
         OP_LONG_R: hit = take_press_flags(take_repeat_flags(sel & press_pend));
         OP_RPT_L:  hit = take_repeat_flags(sel & ~press_pend);
         default:   hit = classify_keys(sel);
      endcase
      rep.reported  = hit;
      rep.key_class = class_now;
      rep.debounced = keys_down;
      return rep;
   endfunction

   always @(posedge clock) begin
      key_report_type seen;
      key_report_type want;
      if (reset) begin
         rpt_key_set   = RST_REPEAT_KEYS;
         start_delay   = RST_START_DELAY;
         repeat_period = RST_INTERVAL;
         very_long_lim = RST_VERY_LONG_LIM;
         vc_low        = 8'hFF;
         vc_high       = 8'hFF;
         keys_down     = 8'h00;
         press_pend    = 8'h00;
         repeat_pend   = 8'h00;
         repeat_timer  = 8'h00;
         hold_ticks    = 8'h00;
         class_now     = CLASS_NONE;
         report_q.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (reg_index_type'(csr_paddr[3:2]))
               REG_REPEAT_KEYS:   rpt_key_set   = csr_pwdata[7:0];
               REG_START_DELAY:   start_delay   = csr_pwdata[7:0];
               REG_INTERVAL:      repeat_period = csr_pwdata[7:0];
               REG_VERY_LONG_LIM: very_long_lim = csr_pwdata[7:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready)
            report_q.push_back(predict_report(op_type'(req_operation), req_pin_levels,
                                              req_key_select));
         if (rsp_valid && rsp_ready) begin
            seen = {rsp_selected_keys, rsp_key_class, rsp_debounced_keys};
            beat_no++;
            if (report_q.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("result %0d: nothing outstanding, got %h class %0d keys %h",
                           beat_no, seen.reported, seen.key_class, seen.debounced);
            end else begin
               want = report_q.pop_front();
               if (seen !== want) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("result %0d: expected %h/%0d/%h, got %h/%0d/%h",
                              beat_no, want.reported, want.key_class, want.debounced,
                              seen.reported, seen.key_class, seen.debounced);
               end
            end
         end
      end
      fail_count    <= mismatches;
      pending_count <= report_q.size();
   end

endmodule

// ===== verif/key_debounce_repeat_classifier_core_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// key_debounce_repeat_classifier_core_test
// Drives the key debounce core with pin ticks, flag queries and classify
// steps: a short directed pass, then phases of press and release episodes
// with bouncing pins under several register settings, with random idle
// cycles on the request side and random stalls on the result side.
// ----------------------------------------------------------------------------
module key_debounce_repeat_classifier_core_test;
   import kdrc_pkg::*;

   localparam int CYCLE_LIMIT = 500000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [2:0]  req_operation = OP_TICK;
   logic [7:0]  req_pin_levels = 8'hFF;
   logic [7:0]  req_key_select = 8'h00;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [7:0]  rsp_selected_keys;
   logic [2:0]  rsp_key_class;
   logic [7:0]  rsp_debounced_keys;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [3:0]  csr_paddr = 4'h0;
   logic [31:0] csr_pwdata = 32'h0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   int fail_count;
   int pending_count;
   int cycle_count = 0;
   int items_sent = 0;
   int stall_left = 0;
   bit calm = 1'b0;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   key_debounce_repeat_classifier_core u_top (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_operation      (req_operation),
      .req_pin_levels     (req_pin_levels),
      .req_key_select     (req_key_select),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_selected_keys  (rsp_selected_keys),
      .rsp_key_class      (rsp_key_class),
      .rsp_debounced_keys (rsp_debounced_keys),
      .csr_psel           (csr_psel),
      .csr_penable        (csr_penable),
      .csr_pwrite         (csr_pwrite),
      .csr_paddr          (csr_paddr),
      .csr_pwdata         (csr_pwdata),
      .csr_prdata         (csr_prdata),
      .csr_pready         (csr_pready)
   );

   key_report_checker u_check (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_operation      (req_operation),
      .req_pin_levels     (req_pin_levels),
      .req_key_select     (req_key_select),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_selected_keys  (rsp_selected_keys),
      .rsp_key_class      (rsp_key_class),
      .rsp_debounced_keys (rsp_debounced_keys),
      .csr_psel           (csr_psel),
      .csr_penable        (csr_penable),
      .csr_pwrite         (csr_pwrite),
      .csr_pready         (csr_pready),
      .csr_paddr          (csr_paddr),
      .csr_pwdata         (csr_pwdata),
      .fail_count         (fail_count),
      .pending_count      (pending_count)
   );

   // mostly short idles, now and then a long one
   function automatic int idle_length();
      if ($urandom_range(0, 9) == 0)
         return $urandom_range(8, 40);
      return $urandom_range(1, 3);
   endfunction

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_ready  <= 1'b0;
      end else if (calm || $urandom_range(0, 99) < 75) begin
         rsp_ready <= 1'b1;
      end else begin
         stall_left <= idle_length() - 1;
         rsp_ready  <= 1'b0;
      end
   end

   task automatic issue_op(input op_type op, input logic [7:0] pins, input logic [7:0] sel);
      int gap;
      gap = 0;
      if (!calm && $urandom_range(0, 99) >= 70)
         gap = idle_length();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_operation  <= op;
      req_pin_levels <= pins;
      req_key_select <= sel;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      items_sent++;
   endtask

   // hold off until every outstanding beat has come back
   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_count != 0);
   endtask

   task automatic csr_write(input reg_index_type idx, input logic [7:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= {24'h0, value};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
   endtask

   task automatic configure(input logic [7:0] keys, input logic [7:0] delay,
                            input logic [7:0] period, input logic [7:0] limit);
      drain();
      repeat (4) @(posedge clock);
      csr_write(REG_REPEAT_KEYS, keys);
      csr_write(REG_START_DELAY, delay);
      csr_write(REG_INTERVAL, period);
      csr_write(REG_VERY_LONG_LIM, limit);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   task automatic random_query(input logic [7:0] keys);
      op_type     op;
      logic [7:0] sel;
      int         pick;
      op = op_type'($urandom_range(1, 7));
      if ($urandom_range(0, 3) == 0)
         op = OP_CLASSIFY;
      pick = $urandom_range(0, 19);
      if (pick < 8)
         sel = keys;
      else if (pick < 13)
         sel = 8'hFF;
      else if (pick < 15)
         sel = 8'h00;
      else
         sel = 8'($urandom_range(0, 255));
      issue_op(op, 8'($urandom_range(0, 255)), sel);
   endtask

   // tick with the given keys down, bouncing on the first few ticks
   task automatic hold_keys(input logic [7:0] keys, input int ticks, input int query_pct);
      logic [7:0] pins;
      for (int i = 0; i < ticks; i++) begin
         pins = ~keys;
         if (i < 3 && $urandom_range(0, 2) == 0)
            pins = pins ^ 8'($urandom_range(1, 255));
         issue_op(OP_TICK, pins, 8'($urandom_range(0, 255)));
         if ($urandom_range(0, 99) < query_pct)
            random_query(keys);
      end
   endtask

   task automatic key_episode(input logic [7:0] keys, input int ticks);
      calm = ($urandom_range(0, 4) == 0);
      hold_keys(keys, ticks, 30);
      hold_keys(8'h00, $urandom_range(3, 10), 30);
      if ($urandom_range(0, 9) < 7)
         issue_op(OP_CLASSIFY, 8'($urandom_range(0, 255)), keys);
   endtask

   task automatic run_phase(input int budget);
      int         target;
      int         roll;
      logic [7:0] keys;
      target = items_sent + budget;
      while (items_sent < target) begin
         roll = $urandom_range(0, 99);
         if (roll < 10) begin
            calm = 1'b0;
            repeat ($urandom_range(1, 5))
               issue_op(op_type'($urandom_range(0, 7)), 8'($urandom_range(0, 255)),
                        8'($urandom_range(0, 255)));
         end else if (roll < 13) begin
            drain();
         end else begin
            roll = $urandom_range(0, 9);
            if (roll < 4)
               keys = 8'(1 << $urandom_range(0, 7));
            else if (roll < 6)
               keys = 8'hFF;
            else
               keys = 8'($urandom_range(1, 255));
            if ($urandom_range(0, 9) == 0)
               key_episode(keys, $urandom_range(40, 120));
            else
               key_episode(keys, $urandom_range(1, 30));
         end
      end
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // short repeat delay and interval, zero very-long limit
      configure(8'hFF, 8'd1, 8'd2, 8'd0);
      issue_op(OP_TICK, 8'hFF, 8'h00);
      issue_op(OP_PRESS, 8'h00, 8'h00);
      issue_op(OP_REPEAT, 8'hFF, 8'hFF);
      repeat (5) issue_op(OP_TICK, 8'h00, 8'hFF);
      issue_op(OP_SHORT, 8'h00, 8'hFF);
      issue_op(OP_RPT_L, 8'h00, 8'hFF);
      issue_op(OP_LONG_R, 8'h00, 8'h0F);
      issue_op(OP_LONG, 8'h00, 8'hF0);
      issue_op(OP_PRESS, 8'h00, 8'hFF);
      issue_op(OP_REPEAT, 8'h00, 8'hFF);
      repeat (2) issue_op(OP_TICK, 8'h00, 8'h00);
      issue_op(OP_CLASSIFY, 8'h00, 8'hFF);
      repeat (4) issue_op(OP_TICK, 8'hFF, 8'h00);
      issue_op(OP_CLASSIFY, 8'hFF, 8'h01);
      issue_op(OP_SHORT, 8'hFF, 8'hFF);
      issue_op(OP_TICK, 8'hAA, 8'h55);
      issue_op(OP_CLASSIFY, 8'h00, 8'h00);

      configure(8'h00, 8'd255, 8'd255, 8'd254);
      run_phase(120);
      configure(8'hFF, 8'd50, 8'd20, 8'd200);
      run_phase(120);
      configure(8'hA5, 8'd3, 8'd1, 8'd10);
      run_phase(120);

      // let the hold count saturate while the class is held
      configure(8'h5A, 8'd2, 8'd1, 8'd254);
      calm = 1'b0;
      hold_keys(8'h18, 12, 0);
      issue_op(OP_CLASSIFY, 8'hFF, 8'h18);
      hold_keys(8'h18, 270, 0);
      issue_op(OP_CLASSIFY, 8'hFF, 8'h18);
      hold_keys(8'h00, 6, 0);
      issue_op(OP_CLASSIFY, 8'hFF, 8'h18);
      run_phase(100);

      configure(8'($urandom_range(1, 254)), 8'($urandom_range(1, 20)),
                8'($urandom_range(1, 10)), 8'($urandom_range(0, 254)));
      run_phase(120);
      configure(8'h01, 8'd1, 8'd255, 8'd0);
      run_phase(120);

      drain();
      repeat (8) @(posedge clock);
      if (fail_count == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule
